### sv/differential_drive_odometry_assert.svh
// Assertion macros for the odometry block checker.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DDO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ddo_pkg.sv
package ddo_pkg;

  localparam int FRAC_BITS        = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [15:0] DIAM_RST = 16'((8 << FRAC_BITS) & 16'hFFFF);
  localparam logic [15:0] BASE_RST = 16'((((161 << FRAC_BITS) + 5) / 10) & 16'hFFFF);

  localparam logic [21:0]        PI_Q20      = 22'd3294199;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [63:0]        MEAN_BIAS   = 64'd360 << 20;
  // ceil(2^43 / 45), split at bit 26; exact floor(v / 45) for v below 2^38
  localparam logic [25:0]        MREC_LO     = 26'd47721859;
  localparam logic [11:0]        MREC_HI     = 12'd2912;
  localparam logic [6:0]         TURN_LAST   = 7'd71;
  localparam logic [6:0]         HALF_STEP   = 7'd70;

  typedef enum logic [7:0] {
    CFG_DIAM    = 8'd0,
    CFG_BASE    = 8'd1,
    CFG_TGT_X   = 8'd2,
    CFG_TGT_Y   = 8'd3,
    CFG_TGT_RAD = 8'd4,
    CFG_ROB_RAD = 8'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_SUM,
    OP_MUL_DIF,
    OP_TDIV_START,
    OP_DIV_STEP,
    OP_TURN_FIX,
    OP_PI_LO,
    OP_PI_HI,
    OP_MR_LOAD,
    OP_MR_LL,
    OP_MR_HL,
    OP_MR_LH,
    OP_MR_HH,
    OP_MEAN_FIX,
    OP_CORD_START,
    OP_CORD_STEP,
    OP_CORD_FIX,
    OP_X_LO,
    OP_X_HI,
    OP_Y_LO,
    OP_Y_HI,
    OP_POSE,
    OP_DIFF,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_R,
    OP_NEAR,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic div_last;
    logic cord_last;
    logic out_free;
  } ddo_stat_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'h20000000;
      5'd1:  return 32'h12E4051E;
      5'd2:  return 32'h09FB385B;
      5'd3:  return 32'h051111D4;
      5'd4:  return 32'h028B0D43;
      5'd5:  return 32'h0145D7E1;
      5'd6:  return 32'h00A2F61E;
      5'd7:  return 32'h00517C55;
      5'd8:  return 32'h0028BE53;
      5'd9:  return 32'h00145F2F;
      5'd10: return 32'h000A2F98;
      5'd11: return 32'h000517CC;
      5'd12: return 32'h00028BE6;
      5'd13: return 32'h000145F3;
      5'd14: return 32'h0000A2FA;
      5'd15: return 32'h0000517D;
      5'd16: return 32'h000028BE;
      5'd17: return 32'h0000145F;
      5'd18: return 32'h00000A30;
      5'd19: return 32'h00000518;
      5'd20: return 32'h0000028C;
      5'd21: return 32'h00000146;
      5'd22: return 32'h000000A3;
      5'd23: return 32'h00000051;
      5'd24: return 32'h00000029;
      5'd25: return 32'h00000014;
      5'd26: return 32'h0000000A;
      5'd27: return 32'h00000005;
      5'd28: return 32'h00000003;
      5'd29: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

### sv/ddo_ctrl.sv
module ddo_ctrl import ddo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ddo_stat_t stat,
  output op_t       op
);

  typedef enum logic [4:0] {
    S_IDLE, S_MSUM, S_MDIF, S_TDIV0, S_TDIV, S_TFIX, S_PILO, S_PIHI,
    S_MRLD, S_MRLL, S_MRHL, S_MRLH, S_MRHH, S_MFIX, S_CRD0, S_CRD, S_CFIX,
    S_XLO, S_XHI, S_YLO, S_YHI, S_POSE, S_DIFF, S_SQX, S_SQY, S_SQR, S_NEAR,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_MSUM;
        S_MSUM:  state <= S_MDIF;
        S_MDIF:  state <= S_TDIV0;
        S_TDIV0: state <= S_TDIV;
        S_TDIV:  if (stat.div_last) state <= S_TFIX;
        S_TFIX:  state <= S_PILO;
        S_PILO:  state <= S_PIHI;
        S_PIHI:  state <= S_MRLD;
        S_MRLD:  state <= S_MRLL;
        S_MRLL:  state <= S_MRHL;
        S_MRHL:  state <= S_MRLH;
        S_MRLH:  state <= S_MRHH;
        S_MRHH:  state <= S_MFIX;
        S_MFIX:  state <= S_CRD0;
        S_CRD0:  state <= S_CRD;
        S_CRD:   if (stat.cord_last) state <= S_CFIX;
        S_CFIX:  state <= S_XLO;
        S_XLO:   state <= S_XHI;
        S_XHI:   state <= S_YLO;
        S_YLO:   state <= S_YHI;
        S_YHI:   state <= S_POSE;
        S_POSE:  state <= S_DIFF;
        S_DIFF:  state <= S_SQX;
        S_SQX:   state <= S_SQY;
        S_SQY:   state <= S_SQR;
        S_SQR:   state <= S_NEAR;
        S_NEAR:  state <= S_OUT;
        S_OUT:   if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:  op = in_valid ? OP_LOAD : OP_IDLE;
      S_MSUM:  op = OP_MUL_SUM;
      S_MDIF:  op = OP_MUL_DIF;
      S_TDIV0: op = OP_TDIV_START;
      S_TDIV:  op = OP_DIV_STEP;
      S_TFIX:  op = OP_TURN_FIX;
      S_PILO:  op = OP_PI_LO;
      S_PIHI:  op = OP_PI_HI;
      S_MRLD:  op = OP_MR_LOAD;
      S_MRLL:  op = OP_MR_LL;
      S_MRHL:  op = OP_MR_HL;
      S_MRLH:  op = OP_MR_LH;
      S_MRHH:  op = OP_MR_HH;
      S_MFIX:  op = OP_MEAN_FIX;
      S_CRD0:  op = OP_CORD_START;
      S_CRD:   op = OP_CORD_STEP;
      S_CFIX:  op = OP_CORD_FIX;
      S_XLO:   op = OP_X_LO;
      S_XHI:   op = OP_X_HI;
      S_YLO:   op = OP_Y_LO;
      S_YHI:   op = OP_Y_HI;
      S_POSE:  op = OP_POSE;
      S_DIFF:  op = OP_DIFF;
      S_SQX:   op = OP_SQ_X;
      S_SQY:   op = OP_SQ_Y;
      S_SQR:   op = OP_SQ_R;
      S_NEAR:  op = OP_NEAR;
      S_OUT:   op = stat.out_free ? OP_OUT : OP_IDLE;
      default: op = OP_IDLE;
    endcase
  end

endmodule

### sv/ddo_datapath.sv
module ddo_datapath import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  output ddo_stat_t          stat,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] right_count,
  input  logic signed [31:0] left_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic               near_target
);

  localparam logic [6:0] CORD_LAST = 7'(CORDIC_STEPS - 1);

  function automatic logic signed [24:0] sat_delta(input logic signed [32:0] d);
    if (d > 33'sd8388608) return 25'sd8388608;
    else if (d < -33'sd8388608) return -25'sd8388608;
    else return d[24:0];
  endfunction

  // configuration
  logic [15:0]        diam, base;
  logic signed [31:0] tgt_x, tgt_y;
  logic [23:0]        tgt_rad, rob_rad;

  // odometry state
  logic signed [31:0] prev_r, prev_l, pose_x, pose_y;
  logic [31:0]        pose_hd;

  // working registers
  logic signed [25:0] sum_w, dif_w;
  logic [24:0]        den;
  logic signed [41:0] nsum;
  logic signed [60:0] prod;
  logic signed [63:0] acc;
  logic [71:0]        dvd;
  logic [24:0]        rem, dvsr, half_r;
  logic [31:0]        quo;
  logic [6:0]         cnt;
  logic [31:0]        half_q, half_t, full_t;
  logic               neg_t, neg_m;
  logic [40:0]        smag;
  logic [37:0]        vq;
  logic [75:0]        racc;
  logic signed [33:0] mean;
  logic signed [33:0] cx, cy, cos_r, sin_r;
  logic signed [32:0] cz;
  logic               flip;
  logic signed [32:0] dx, dy;
  logic [24:0]        rr;
  logic               far, near_r;

  // input deltas
  logic signed [24:0] dr, dl;
  logic [15:0]        base_eff;
  logic [24:0]        den_next;
  assign dr = sat_delta(33'(right_count) - 33'(prev_r));
  assign dl = sat_delta(33'(left_count) - 33'(prev_l));
  assign base_eff = (base == 16'd0) ? 16'd1 : base;
  // 360 = 256 + 64 + 32 + 8
  assign den_next = {1'b0, base_eff, 8'b0} + {3'b0, base_eff, 6'b0}
                  + {4'b0, base_eff, 5'b0} + {6'b0, base_eff, 3'b0};

  // shared multiplier
  logic signed [26:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [60:0] mul_p;
  always_comb begin
    case (op)
      OP_MUL_SUM: begin mul_a = {sum_w[25], sum_w}; mul_b = {18'b0, diam}; end
      OP_MUL_DIF: begin mul_a = {dif_w[25], dif_w}; mul_b = {18'b0, diam}; end
      OP_PI_LO:   begin mul_a = {6'b0, smag[20:0]}; mul_b = {12'b0, PI_Q20}; end
      OP_PI_HI:   begin mul_a = {7'b0, smag[40:21]}; mul_b = {12'b0, PI_Q20}; end
      OP_MR_LL:   begin mul_a = {1'b0, MREC_LO}; mul_b = {1'b0, vq[32:0]}; end
      OP_MR_HL:   begin mul_a = {15'b0, MREC_HI}; mul_b = {1'b0, vq[32:0]}; end
      OP_MR_LH:   begin mul_a = {1'b0, MREC_LO}; mul_b = {29'b0, vq[37:33]}; end
      OP_MR_HH:   begin mul_a = {15'b0, MREC_HI}; mul_b = {29'b0, vq[37:33]}; end
      OP_X_LO:    begin mul_a = {10'b0, mean[16:0]}; mul_b = cos_r; end
      OP_X_HI:    begin mul_a = {{10{mean[33]}}, mean[33:17]}; mul_b = cos_r; end
      OP_Y_LO:    begin mul_a = {10'b0, mean[16:0]}; mul_b = sin_r; end
      OP_Y_HI:    begin mul_a = {{10{mean[33]}}, mean[33:17]}; mul_b = sin_r; end
      OP_SQ_X:    begin mul_a = dx[26:0]; mul_b = {{7{dx[26]}}, dx[26:0]}; end
      OP_SQ_Y:    begin mul_a = dy[26:0]; mul_b = {{7{dy[26]}}, dy[26:0]}; end
      OP_SQ_R:    begin mul_a = {2'b0, rr}; mul_b = {9'b0, rr}; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // radix-2 restoring divider step
  logic [25:0] trial;
  logic        ge;
  logic [24:0] rem_n;
  logic [31:0] quo_n;
  assign trial = {rem, dvd[71]};
  assign ge    = trial >= {1'b0, dvsr};
  assign rem_n = ge ? 25'(trial - {1'b0, dvsr}) : trial[24:0];
  assign quo_n = {quo[30:0], ge};

  // turn rounding and sign
  logic [24:0] half_den;
  logic        full_up, half_up;
  logic [31:0] full_m, half_m;
  assign half_den = dvsr >> 1;
  assign full_up  = ({1'b0, rem} + {1'b0, half_den}) >= {1'b0, dvsr};
  assign half_up  = ({1'b0, half_r} + {1'b0, half_den}) >= {1'b0, dvsr};
  assign full_m   = quo + {31'b0, full_up};
  assign half_m   = half_q + {31'b0, half_up};

  // magnitude of the signed numerator from the multiplier
  logic [41:0] pm, pm_neg;
  assign pm     = prod[41:0];
  assign pm_neg = -pm;

  // mean travel dividend
  logic [63:0] mval;
  assign mval = $unsigned(acc) + {prod[42:0], 21'b0};

  // divide by 45 through the reciprocal: last partial product, then >> 43
  logic [75:0] rsum;
  logic [33:0] mq;
  assign rsum = racc + {prod[16:0], 59'b0};
  assign mq   = {1'b0, rsum[75:43]};

  // CORDIC
  logic [31:0]        ang, ang_rot;
  logic               ang_flip;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;
  assign ang      = pose_hd + half_t;
  assign ang_flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_rot  = ang_flip ? (ang ^ 32'h80000000) : ang;
  assign xs       = cx >>> cnt[4:0];
  assign ys       = cy >>> cnt[4:0];
  assign at       = {1'b0, atan_bam(cnt[4:0])};

  // pose increment: bits 30..61 of the rounded product sum
  logic [63:0] tot;
  assign tot = $unsigned(acc) + {prod[46:0], 17'b0};

  assign stat.div_last  = (cnt == TURN_LAST);
  assign stat.cord_last = (cnt == CORD_LAST);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      diam      <= DIAM_RST;
      base      <= BASE_RST;
      tgt_x     <= '0;
      tgt_y     <= '0;
      tgt_rad   <= '0;
      rob_rad   <= '0;
      prev_r    <= '0;
      prev_l    <= '0;
      pose_x    <= '0;
      pose_y    <= '0;
      pose_hd   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DIAM:    diam    <= cfg_data[15:0];
          CFG_BASE:    base    <= cfg_data[15:0];
          CFG_TGT_X:   tgt_x   <= cfg_data;
          CFG_TGT_Y:   tgt_y   <= cfg_data;
          CFG_TGT_RAD: tgt_rad <= cfg_data[23:0];
          CFG_ROB_RAD: rob_rad <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (op)
        OP_LOAD: begin
          prev_r <= right_count;
          prev_l <= left_count;
        end
        OP_Y_LO: pose_x <= pose_x + tot[61:30];
        OP_POSE: begin
          pose_y  <= pose_y + tot[61:30];
          pose_hd <= pose_hd + full_t;
        end
        default: ;
      endcase
    end
  end

  // datapath payload, no reset
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        sum_w <= 26'(dr) + 26'(dl);
        dif_w <= 26'(dr) - 26'(dl);
        den   <= den_next;
      end
      OP_MUL_SUM: prod <= mul_p;
      OP_MUL_DIF: begin
        nsum <= prod[41:0];
        prod <= mul_p;
      end
      OP_TDIV_START: begin
        neg_t <= pm[41];
        dvd   <= {(pm[41] ? pm_neg[40:0] : pm[40:0]), 31'b0};
        rem   <= '0;
        quo   <= '0;
        cnt   <= '0;
        dvsr  <= den;
      end
      OP_DIV_STEP: begin
        rem <= rem_n;
        quo <= quo_n;
        dvd <= {dvd[70:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == HALF_STEP) begin
          half_q <= quo_n;
          half_r <= rem_n;
        end
      end
      OP_TURN_FIX: begin
        full_t <= neg_t ? -full_m : full_m;
        half_t <= neg_t ? -half_m : half_m;
        neg_m  <= nsum[41];
        smag   <= nsum[41] ? 41'(-nsum) : nsum[40:0];
      end
      OP_PI_LO: prod <= mul_p;
      OP_PI_HI: begin
        acc  <= $signed({3'b0, prod} + MEAN_BIAS);
        prod <= mul_p;
      end
      OP_MR_LOAD: vq <= mval[61:24];
      OP_MR_LL: prod <= mul_p;
      OP_MR_HL: begin
        racc <= {15'b0, prod};
        prod <= mul_p;
      end
      OP_MR_LH: begin
        racc <= racc + {5'b0, prod[44:0], 26'b0};
        prod <= mul_p;
      end
      OP_MR_HH: begin
        racc <= racc + {12'b0, prod[30:0], 33'b0};
        prod <= mul_p;
      end
      OP_MEAN_FIX: mean <= neg_m ? $signed(-mq) : $signed(mq);
      OP_CORD_START: begin
        cx   <= CORDIC_GAIN;
        cy   <= '0;
        cz   <= {ang_rot[31], ang_rot};
        flip <= ang_flip;
        cnt  <= '0;
      end
      OP_CORD_STEP: begin
        if (!cz[32]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
        cnt <= cnt + 7'd1;
      end
      OP_CORD_FIX: begin
        cos_r <= flip ? -cx : cx;
        sin_r <= flip ? -cy : cy;
      end
      OP_X_LO: prod <= mul_p;
      OP_X_HI: begin
        acc  <= {{3{prod[60]}}, prod} + 64'sd536870912;
        prod <= mul_p;
      end
      OP_Y_LO: prod <= mul_p;
      OP_Y_HI: begin
        acc  <= {{3{prod[60]}}, prod} + 64'sd536870912;
        prod <= mul_p;
      end
      OP_DIFF: begin
        dx <= 33'(tgt_x) - 33'(pose_x);
        dy <= 33'(tgt_y) - 33'(pose_y);
        rr <= {1'b0, tgt_rad} + {1'b0, rob_rad};
      end
      OP_SQ_X: begin
        prod <= mul_p;
        far  <= (dx > 33'sd33554432) || (dx < -33'sd33554432)
             || (dy > 33'sd33554432) || (dy < -33'sd33554432);
      end
      OP_SQ_Y: begin
        acc  <= {{3{prod[60]}}, prod};
        prod <= mul_p;
      end
      OP_SQ_R: begin
        acc  <= acc + {{3{prod[60]}}, prod};
        prod <= mul_p;
      end
      OP_NEAR: near_r <= !far && (acc <= {{3{prod[60]}}, prod});
      OP_OUT: begin
        pos_x       <= pose_x;
        pos_y       <= pose_y;
        heading     <= pose_hd;
        near_target <= near_r;
      end
      default: ;
    endcase
  end

endmodule

### sv/differential_drive_odometry.sv
// Differential-drive wheel odometry. Each input word carries the absolute
// right and left encoder angles in degrees; the block differences them
// against the last word (deltas clamp at +-2^23 degrees), turns them into
// wheel travel, and advances the pose along the midpoint heading using an
// iterative CORDIC, then adds the full turn. Positions are signed, in
// 1/256 cm, and wrap at 32 bits; the heading is a 32-bit binary angle. Every
// input word yields exactly one output word with the new pose and a flag
// that is high when the pose is within the goal radius plus the robot radius
// of the goal point. Items are handled one at a time; the work runs through
// the shared radix-2 divider, which runs 72 steps for the turn angle, through
// the CORDIC at one step per cycle, and through the mean travel, which divides
// by a constant through a reciprocal taken in four passes of the shared
// multiplier. The output word sits in its own register, so the next input is
// taken as soon as the result is parked, even if downstream has not yet
// taken it. Configuration registers (index 0..5: wheel diameter, wheel base,
// goal x, goal y, goal radius, robot radius) are written through the cfg
// channel, which is always ready; other indexes are dropped. Write them only
// while the block is idle.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] right_count,
  input  logic signed [31:0] left_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic               near_target,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  op_t       op;
  ddo_stat_t stat;

  // configuration writes are always taken and land straight in the registers
  assign cfg_ready = 1'b1;

  // sequencer: one command per cycle to the datapath
  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // arithmetic: multiplier, divider, CORDIC, pose and config registers
  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .right_count (right_count),
    .left_count  (left_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .near_target (near_target)
  );

endmodule

### sv/ddo_checker.sv
`include "differential_drive_odometry_assert.svh"

module ddo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] right_count,
  input logic [31:0] left_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [31:0] heading,
  input logic        near_target,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // a stalled output word holds
  `DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading) && $stable(near_target), "output word changed while stalled")

  // one item at a time: busy right after an accept
  `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted while busy")

  // leave reset idle and ready
  `DDO_ASSERT_NOW(a_reset_idle, $past(rst), !out_valid && in_ready, "not idle after reset")

  // a new word comes only from a busy block
  `DDO_ASSERT_NOW(a_word_from_work, $rose(out_valid), $past(!in_ready), "output word without work")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

### bench/testbench.sv
module testbench;
  import ddo_pkg::*;

  // Index outside the register map: the block must drop such writes.
  localparam logic [7:0] CFG_NONE    = 8'd9;
  localparam logic [7:0] CFG_TOP     = 8'hFF;
  localparam int         QUIET_LIMIT = 5000;
  localparam int         DRAIN_WAIT  = 200;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 105;
  localparam longint     JUMP_LIM    = 64'sd8388608;
  localparam longint     FAR_LIM     = 64'sd33554432;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [31:0]        h;
    logic               near;
  } pose_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [7:0]         idx;
    logic [31:0]        data;
    logic signed [31:0] right;
    logic signed [31:0] left;
    logic               typed;
    pose_t              want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] right_count = '0;
  logic signed [31:0] left_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic               near_target;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  differential_drive_odometry u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .right_count(right_count), .left_count(left_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .near_target(near_target),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block: registers, encoder history and pose.
  logic [15:0]        m_diam = DIAM_RST;
  logic [15:0]        m_base = BASE_RST;
  logic signed [31:0] m_tgt_x = '0;
  logic signed [31:0] m_tgt_y = '0;
  logic [23:0]        m_tgt_rad = '0;
  logic [23:0]        m_rob_rad = '0;
  logic signed [31:0] m_prev_r = '0;
  logic signed [31:0] m_prev_l = '0;
  logic signed [31:0] m_x = '0;
  logic signed [31:0] m_y = '0;
  logic [31:0]        m_h = '0;

  pose_t pose_queue[$];
  int    n_errors = 0;
  int    n_words = 0;
  int    n_poses = 0;
  int    n_near = 0;
  bit    idling = 1'b1;
  int    quiet = 0;
  int    stall_left = 0;

  function automatic longint clamp_jump(longint d);
    if (d > JUMP_LIM) return JUMP_LIM;
    if (d < -JUMP_LIM) return -JUMP_LIM;
    return d;
  endfunction

  // Travel difference over 360*base as a binary angle, rounded half away.
  function automatic logic [31:0] turn_angle(longint n, longint unsigned den, int sh);
    longint unsigned mag, q, r, res;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = mag / den;
    r = mag % den;
    res = (q << sh) + (((r << sh) + den / 2) / den);
    if (n < 0) res = -res;
    return res[31:0];
  endfunction

  // Rotate the Q30 gain vector to the angle; fold the back half first.
  function automatic void rotate(input logic [31:0] ang, output longint c,
                                 output longint s);
    longint x, y, z, xs, ys;
    bit flip;
    x = 64'sd652032875;
    y = 0;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h80000000;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_bam(5'(i)));
      end else begin
        x += ys; y -= xs; z += longint'(atan_bam(5'(i)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the shadow pose by one encoder word and return the new pose.
  function automatic pose_t advance_pose(logic signed [31:0] rc, logic signed [31:0] lc);
    longint dr, dl, d, sum, mean, nt, c, s, dx, dy, ax, ay, rr;
    longint unsigned den, smag, mmag, mdiv;
    logic [31:0] half, full;
    pose_t p;
    dr = clamp_jump(longint'(rc) - longint'(m_prev_r));
    dl = clamp_jump(longint'(lc) - longint'(m_prev_l));
    d = longint'(m_diam);
    den = 360 * ((m_base == 0) ? 1 : longint'(m_base));
    sum = d * (dr + dl);
    smag = (sum < 0) ? longint'(-sum) : longint'(sum);
    mdiv = 64'd720 << 20;
    mmag = (smag * 64'(PI_Q20) + mdiv / 2) / mdiv;
    mean = (sum < 0) ? -longint'(mmag) : longint'(mmag);
    nt = d * (dr - dl);
    half = turn_angle(nt, den, 30);
    full = turn_angle(nt, den, 31);
    rotate(m_h + half, c, s);
    m_x = m_x + 32'((mean * c + (longint'(1) <<< 29)) >>> 30);
    m_y = m_y + 32'((mean * s + (longint'(1) <<< 29)) >>> 30);
    m_h = m_h + full;
    m_prev_r = rc;
    m_prev_l = lc;
    dx = longint'(m_tgt_x) - longint'(m_x);
    dy = longint'(m_tgt_y) - longint'(m_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    rr = longint'(m_tgt_rad) + longint'(m_rob_rad);
    p.x = m_x;
    p.y = m_y;
    p.h = m_h;
    p.near = (ax <= FAR_LIM) && (ay <= FAR_LIM) && (ax * ax + ay * ay <= rr * rr);
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on word %0d: %s got %h, expected %h", n_poses, field, got, want);
    n_errors++;
  endtask

  // Present one encoder word and hold it until taken. Valid stays high on
  // return so a back-to-back word follows without a gap; callers drop it otherwise.
  task automatic send_counts(logic signed [31:0] r, logic signed [31:0] l, bit typed,
                             pose_t want);
    pose_t p;
    cfg_valid   <= 1'b0;
    in_valid    <= 1'b1;
    right_count <= r;
    left_count  <= l;
    do @(posedge clk); while (!in_ready);
    p = advance_pose(r, l);
    pose_queue.push_back(typed ? want : p);
    n_words++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIAM:    m_diam = data[15:0];
      CFG_BASE:    m_base = data[15:0];
      CFG_TGT_X:   m_tgt_x = data;
      CFG_TGT_Y:   m_tgt_y = data;
      CFG_TGT_RAD: m_tgt_rad = data[23:0];
      CFG_ROB_RAD: m_rob_rad = data[23:0];
      default: ;
    endcase
  endtask

  // Drop valid and hold until every pose in flight has come back.
  task automatic drain;
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pose_queue.size() != 0) @(posedge clk);
  endtask

  task automatic sender_gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic row_t word_row(logic signed [31:0] r, logic signed [31:0] l);
    row_t w;
    w = '0;
    w.kind = ROW_WORD;
    w.right = r;
    w.left = l;
    return w;
  endfunction

  function automatic row_t reg_row(logic [7:0] idx, logic [31:0] data);
    row_t w;
    w = '0;
    w.kind = ROW_REG;
    w.idx = idx;
    w.data = data;
    return w;
  endfunction

  // Random encoder pair: mostly small wheel moves, with noise and jumps.
  task automatic random_word;
    int mode;
    logic signed [31:0] r, l;
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      r = m_prev_r + $signed($urandom_range(0, 1440)) - 720;
      l = m_prev_l + $signed($urandom_range(0, 1440)) - 720;
    end else if (mode == 7) begin
      r = $urandom;
      l = $urandom;
    end else if (mode == 8) begin
      r = m_prev_r + ($urandom_range(0, 1) ? 32'sd8388608 : -32'sd8388608)
          + $signed($urandom_range(0, 4)) - 2;
      l = m_prev_l - $signed($urandom_range(0, 360));
    end else begin
      r = m_prev_r;
      l = m_prev_l;
    end
    sender_gap();
    send_counts(r, l, 1'b0, '0);
  endtask

  // Receiver side: stall in bursts, check every pose, run the watchdog.
  always @(posedge clk) begin
    pose_t want;
    logic ready_next;
    if (!rst && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $display("unexpected pose word x=%h y=%h", pos_x, pos_y);
        n_errors++;
      end else begin
        want = pose_queue.pop_front();
        if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
        if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
        if (heading !== want.h) report_mismatch("heading", heading, want.h);
        if (near_target !== want.near)
          report_mismatch("near_target", 32'(near_target), 32'(want.near));
        if (want.near) n_near++;
      end
      n_poses++;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      ready_next = 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_ready <= ready_next;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    row_t plan[$];
    row_t w;
    pose_t first;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Standing still after reset: pose stays at the origin, which is the
    // target with zero radius, so the flag is set.
    w = word_row(32'sd0, 32'sd0);
    first = '0;
    first.near = 1'b1;
    w.typed = 1'b1;
    w.want = first;
    plan.push_back(w);
    plan.push_back(word_row(32'sd360, 32'sd360));
    plan.push_back(word_row(32'sd1080, 32'sd360));
    plan.push_back(word_row(-32'sd1000, 32'sd2000));
    // Encoder jumps far beyond the clamp, both signs.
    plan.push_back(word_row(32'sh7FFFFFFF, 32'sh80000000));
    plan.push_back(word_row(32'sh80000000, 32'sh7FFFFFFF));
    plan.push_back(word_row(32'sh80000000, 32'sh80000000));
    // Zero wheel base behaves as one.
    plan.push_back(reg_row(CFG_BASE, 32'd0));
    plan.push_back(word_row(32'sh80000100, 32'sh80000000));
    // Zero diameter: no travel, no turn.
    plan.push_back(reg_row(CFG_DIAM, 32'd0));
    plan.push_back(word_row(32'sd12345, -32'sd777));
    // Largest geometry, then smallest.
    plan.push_back(reg_row(CFG_DIAM, 32'hFFFF));
    plan.push_back(reg_row(CFG_BASE, 32'hFFFF));
    plan.push_back(word_row(32'sd20000, -32'sd20000));
    plan.push_back(reg_row(CFG_DIAM, 32'd1));
    plan.push_back(reg_row(CFG_BASE, 32'd1));
    plan.push_back(word_row(32'sd20360, -32'sd20000));
    // Far target with the widest radii, then writes to unmapped indexes.
    plan.push_back(reg_row(CFG_TGT_X, 32'h7FFFFFFF));
    plan.push_back(reg_row(CFG_TGT_Y, 32'h80000000));
    plan.push_back(reg_row(CFG_TGT_RAD, 32'hFFFFFF));
    plan.push_back(reg_row(CFG_ROB_RAD, 32'hFFFFFF));
    plan.push_back(reg_row(CFG_NONE, 32'hFFFFFFFF));
    plan.push_back(reg_row(CFG_TOP, 32'h0));
    plan.push_back(word_row(32'sd20720, -32'sd20000));
    plan.push_back(reg_row(CFG_TGT_X, 32'h0));
    plan.push_back(reg_row(CFG_TGT_Y, 32'h0));
    plan.push_back(word_row(32'sd20720, -32'sd20360));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i - 1].kind != ROW_REG) drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        sender_gap();
        send_counts(plan[i].right, plan[i].left, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      idling = (ph < PHASES - 1);
      if (ph == 0) begin
        write_reg(CFG_DIAM, 32'(DIAM_RST));
        write_reg(CFG_BASE, 32'(BASE_RST));
      end else if (ph == 1) begin
        write_reg(CFG_DIAM, 32'hFFFF);
        write_reg(CFG_BASE, 32'd1);
      end else begin
        write_reg(CFG_DIAM, $urandom_range(1, 4096));
        write_reg(CFG_BASE, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 65535));
      end
      // Put the target close to the current pose so the flag toggles.
      write_reg(CFG_TGT_X, m_x + $signed($urandom_range(0, 8000)) - 4000);
      write_reg(CFG_TGT_Y, m_y + $signed($urandom_range(0, 8000)) - 4000);
      write_reg(CFG_TGT_RAD, (ph == 1) ? 32'hFFFFFF : $urandom_range(0, 3000));
      write_reg(CFG_ROB_RAD, (ph == 1) ? 32'h0 : $urandom_range(0, 3000));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off once mid-run until the pipeline is empty.
        if (ph == 2 && k == PHASE_ITEMS / 2) drain();
        random_word();
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d encoder words, %0d poses checked, %0d near the target", n_words,
             n_poses, n_near);
    $display("covered clamped jumps, zero base and diameter, extremes, ignored writes");
    if (n_errors == 0 && pose_queue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
